@@ rtl/core/hbm_pkg.sv @@
package hbm_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RAW_Q_W  = 24;
  localparam int unsigned SUM_Q_W  = 32;
  localparam int unsigned THR_W    = 24;
  localparam int unsigned WID_W    = 16;
  localparam int unsigned CFG_D_W  = 24;

  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RST = THR_W'(256);
  localparam logic [WID_W-1:0] MINW_RST = WID_W'(0);
  localparam logic [WID_W-1:0] MAXW_RST = WID_W'(3200);

  typedef enum logic [1:0] {
    CFG_CHARGE_THRESHOLD = 2'd0,
    CFG_MINIMUM_WIDTH    = 2'd1,
    CFG_MAXIMUM_WIDTH    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  raw_start;
    logic [TIME_W-1:0]  raw_end;
    logic [RAW_Q_W-1:0] raw_charge;
    logic               raw_last;
  } raw_bin_t;

  typedef struct packed {
    logic [TIME_W-1:0]  merged_start;
    logic [TIME_W-1:0]  merged_end;
    logic [SUM_Q_W-1:0] merged_charge;
    logic               merged_last;
  } merged_bin_t;

  typedef struct packed {
    logic [THR_W-1:0] charge_threshold;
    logic [WID_W-1:0] minimum_width;
    logic [WID_W-1:0] maximum_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  num;
    merged_bin_t res0;
    merged_bin_t res1;
  } step_res_t;

endpackage

@@ rtl/core/histogram_bin_merger_unit.sv @@
// Histogram bin merger.
// Input channel (in_valid, in_stall, in_data): one raw time bin per
// transaction, contiguous in time, raw_last set on the final bin of a readout.
// Output channel (out_valid, out_stall, out_data): one merged bin per
// transaction, merged_last set on the final bin of a readout.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
// always ready; write only while no raw bin is in flight.
// A raw bin accepted into the input register enters the output queue once the
// queue has two free slots; its first result, if any, is offered from then on,
// behind any merged bins already queued.
// Throughput: one raw bin per cycle, limited by the output port at one merged
// bin per cycle; a raw bin that closes a group and ends the readout yields two
// merged bins. A held raw bin stays in the input register and in_stall
// rises while the four-entry output queue has fewer than two free slots.
// A stalled receiver fills the queue, then stalls the input; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and queue, closes any
// open group and loads the register defaults.
module histogram_bin_merger_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hbm_pkg::raw_bin_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hbm_pkg::merged_bin_t  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [hbm_pkg::CFG_D_W-1:0] cfg_data
);
  import hbm_pkg::*;

  cfg_t         cfg_r;
  logic         in_valid_r;
  raw_bin_t     in_data_r;
  step_res_t    res;
  logic         adv;
  logic         pop;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  merged_bin_t  q_r [Q_DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_threshold <= THR_RST;
      cfg_r.minimum_width    <= MINW_RST;
      cfg_r.maximum_width    <= MAXW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHARGE_THRESHOLD: cfg_r.charge_threshold <= cfg_data[THR_W-1:0];
        CFG_MINIMUM_WIDTH:    cfg_r.minimum_width    <= cfg_data[WID_W-1:0];
        CFG_MAXIMUM_WIDTH:    cfg_r.maximum_width    <= cfg_data[WID_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = in_valid_r && (cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_stall = in_valid_r && !adv;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && !out_stall;

  hbm_merge_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .bin   (in_data_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r - Q_CNT_W'(pop);
    if (adv) begin
      cnt_nxt = cnt_nxt + Q_CNT_W'(res.num);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        rd_r <= rd_r + Q_PTR_W'(1);
      end
      if (adv) begin
        wr_r <= wr_r + Q_PTR_W'(res.num);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.num != 2'd0) begin
      q_r[wr_r] <= res.res0;
    end
    if (adv && res.num == 2'd2) begin
      q_r[wr_r + Q_PTR_W'(1)] <= res.res1;
    end
  end

`ifndef SYNTH
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_data_r)))
    else $error("stalled input stage lost its bin");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (cnt_r <= $past(cnt_r)))
    else $error("queue grew without an advancing bin");
`endif

endmodule

@@ rtl/core/hbm_merge_core.sv @@
module hbm_merge_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  hbm_pkg::raw_bin_t   bin,
  input  hbm_pkg::cfg_t       cfg,
  output hbm_pkg::step_res_t  res
);
  import hbm_pkg::*;

  logic               open_r, open_nxt;
  logic               first_r, first_nxt;
  logic [TIME_W-1:0]  gstart_r, gstart_nxt;
  logic [SUM_Q_W-1:0] gcharge_r, gcharge_nxt;

  logic [TIME_W:0]    diff;
  logic [TIME_W-1:0]  width;
  logic [SUM_Q_W:0]   sum;
  logic [SUM_Q_W-1:0] sat_sum;
  logic               join_grp;
  logic               closed;
  logic [TIME_W-1:0]  gs_mid;
  logic [SUM_Q_W-1:0] gq_mid;
  merged_bin_t        close_bin;
  merged_bin_t        final_bin;

  always_comb begin
    diff     = {1'b0, bin.raw_end} - {1'b0, gstart_r};
    width    = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    sum      = {1'b0, gcharge_r} + (SUM_Q_W+1)'(bin.raw_charge);
    sat_sum  = sum[SUM_Q_W] ? '1 : sum[SUM_Q_W-1:0];
    join_grp = !first_r && (width < TIME_W'(cfg.maximum_width)) &&
               ((gcharge_r < SUM_Q_W'(cfg.charge_threshold)) ||
                (width < TIME_W'(cfg.minimum_width)));

    closed = 1'b0;
    if (!open_r) begin
      gs_mid = bin.raw_start;
      gq_mid = SUM_Q_W'(bin.raw_charge);
    end else if (join_grp) begin
      gs_mid = gstart_r;
      gq_mid = sat_sum;
    end else begin
      closed = 1'b1;
      gs_mid = bin.raw_start;
      gq_mid = SUM_Q_W'(bin.raw_charge);
    end

    close_bin.merged_start  = gstart_r;
    close_bin.merged_end    = bin.raw_start;
    close_bin.merged_charge = gcharge_r;
    close_bin.merged_last   = 1'b0;

    final_bin.merged_start  = gs_mid;
    final_bin.merged_end    = bin.raw_end;
    final_bin.merged_charge = gq_mid;
    final_bin.merged_last   = 1'b1;

    res.num  = {1'b0, closed} + {1'b0, bin.raw_last};
    res.res0 = closed ? close_bin : final_bin;
    res.res1 = final_bin;

    if (bin.raw_last) begin
      open_nxt    = 1'b0;
      first_nxt   = 1'b0;
      gstart_nxt  = '0;
      gcharge_nxt = '0;
    end else begin
      open_nxt    = 1'b1;
      first_nxt   = !open_r;
      gstart_nxt  = gs_mid;
      gcharge_nxt = gq_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      first_r   <= 1'b0;
      gstart_r  <= '0;
      gcharge_r <= '0;
    end else if (step) begin
      open_r    <= open_nxt;
      first_r   <= first_nxt;
      gstart_r  <= gstart_nxt;
      gcharge_r <= gcharge_nxt;
    end
  end

endmodule
